>>> rtl/lrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared types and constants of the linear interpolation resampler.
// ----------------------------------------------------------------------------
package lrs_pkg;

   localparam int LANES    = 4;
   localparam int SAMPLE_W = 24;
   localparam int PHASE_W  = 20;
   localparam int FRAC_W   = 16;
   localparam int ACH_W    = 3;
   localparam int CSR_IDX_W = 2;

   // running phase needs one more bit than the stored phase
   localparam int PH_W   = PHASE_W + 1;
   localparam int DIFF_W = SAMPLE_W + 1;
   localparam int PROD_W = SAMPLE_W + FRAC_W;
   localparam int CNT_W  = 4;

   localparam logic [PH_W-1:0]  PHASE_ONE   = PH_W'(1) << FRAC_W;
   localparam logic [CNT_W-1:0] MAX_RESULTS = CNT_W'(8);
   localparam logic [CNT_W-1:0] LAST_SLOT   = MAX_RESULTS - CNT_W'(1);

   localparam logic [PHASE_W-1:0] STEP_RESET = PHASE_W'(65536);
   localparam logic [ACH_W-1:0]   ACH_RESET  = ACH_W'(2);

   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_PHASE_STEP = CSR_IDX_W'(0);
   localparam csr_index_type CSR_ACTIVE_CH  = CSR_IDX_W'(1);

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } state_type;

   // control from the sequencer to the lanes and the output stage
   typedef struct packed {
      logic              load;
      logic              issue;
      logic              commit;
      logic              last;
      logic [FRAC_W-1:0] frac;
   } ctl_type;

endpackage

>>> rtl/lrs_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_req_if
// Input frame channel: valid/ready plus four signed samples.
// ----------------------------------------------------------------------------
interface lrs_req_if;
   logic                valid;
   logic                ready;
   lrs_pkg::sample_type sample_0;
   lrs_pkg::sample_type sample_1;
   lrs_pkg::sample_type sample_2;
   lrs_pkg::sample_type sample_3;

   modport source (output valid, output sample_0, output sample_1,
                   output sample_2, output sample_3, input ready);
   modport sink   (input valid, input sample_0, input sample_1,
                   input sample_2, input sample_3, output ready);
endinterface

>>> rtl/lrs_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_rsp_if
// Result frame channel: valid/ready, four signed samples and a run marker.
// ----------------------------------------------------------------------------
interface lrs_rsp_if;
   logic                valid;
   logic                ready;
   lrs_pkg::sample_type out_0;
   lrs_pkg::sample_type out_1;
   lrs_pkg::sample_type out_2;
   lrs_pkg::sample_type out_3;
   logic                last_of_run;

   modport source (output valid, output out_0, output out_1, output out_2,
                   output out_3, output last_of_run, input ready);
   modport sink   (input valid, input out_0, input out_1, input out_2,
                   input out_3, input last_of_run, output ready);
endinterface

>>> rtl/lrs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_ctrl
// Phase sequencer: walks the phase across one input frame, one result a cycle unless the output stalls.
// ----------------------------------------------------------------------------
module lrs_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [lrs_pkg::PHASE_W-1:0]  phase_step,
   input  logic                         advance,
   output lrs_pkg::ctl_type             ctl
);

   lrs_pkg::state_type              state_ff, state_in;
   logic [lrs_pkg::PH_W-1:0]        ph_ff, ph_in;
   logic [lrs_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [lrs_pkg::PH_W-1:0]        ph_next;
   logic                            more;

   assign ph_next = ph_ff + {1'b0, phase_step};
   assign more    = (ph_ff < lrs_pkg::PHASE_ONE) && (cnt_ff < lrs_pkg::MAX_RESULTS);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lrs_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = lrs_pkg::ST_RUN;
            end
         end
         lrs_pkg::ST_RUN: begin
            if (!more) begin
               state_in = lrs_pkg::ST_IDLE;
            end
         end
         default: state_in = lrs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      ctl.load   = 1'b0;
      ctl.issue  = 1'b0;
      ctl.commit = 1'b0;
      ctl.last   = (cnt_ff == lrs_pkg::LAST_SLOT) || (ph_next >= lrs_pkg::PHASE_ONE);
      ctl.frac   = ph_ff[lrs_pkg::FRAC_W-1:0];
      case (state_ff)
         lrs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            ctl.load  = req_valid;
         end
         lrs_pkg::ST_RUN: begin
            ctl.issue  = more && advance;
            ctl.commit = !more;
         end
         default: req_ready = 1'b0;
      endcase
   end

   always_comb begin
      ph_in  = ph_ff;
      cnt_in = cnt_ff;
      if (ctl.load) begin
         cnt_in = '0;
      end
      if (ctl.issue) begin
         ph_in  = ph_next;
         cnt_in = cnt_ff + lrs_pkg::CNT_W'(1);
      end
      if (ctl.commit && (ph_ff >= lrs_pkg::PHASE_ONE)) begin
         ph_in = ph_ff - lrs_pkg::PHASE_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrs_pkg::ST_IDLE;
         ph_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

>>> rtl/lrs_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_lane
// One channel: holds current and previous sample, multiplies the difference
// by the phase fraction and adds the floored product back to the previous.
// ----------------------------------------------------------------------------
module lrs_lane (
   input  logic                 clock,
   input  logic                 reset,
   input  lrs_pkg::ctl_type     ctl,
   input  lrs_pkg::sample_type  sample,
   output lrs_pkg::sample_type  result
);

   lrs_pkg::sample_type                   cur_ff;
   lrs_pkg::sample_type                   prev_ff;
   lrs_pkg::sample_type                   base_ff;
   logic signed [lrs_pkg::PROD_W-1:0]     prod_ff;
   logic signed [lrs_pkg::DIFF_W-1:0]     diff;
   logic signed [lrs_pkg::FRAC_W:0]       frac_s;
   logic signed [lrs_pkg::DIFF_W+lrs_pkg::FRAC_W:0] prod_full;

   assign diff      = lrs_pkg::DIFF_W'(cur_ff) - lrs_pkg::DIFF_W'(prev_ff);
   assign frac_s    = $signed({1'b0, ctl.frac});
   assign prod_full = diff * frac_s;

   // arithmetic shift by the fraction width; the sum wraps to sample width
   assign result = base_ff + $signed(prod_ff[lrs_pkg::FRAC_W +: lrs_pkg::SAMPLE_W]);

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cur_ff <= sample;
      end
      if (ctl.issue) begin
         base_ff <= prev_ff;
         prod_ff <= prod_full[lrs_pkg::PROD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (ctl.commit) begin
         prev_ff <= cur_ff;
      end
   end

endmodule

>>> rtl/lrs_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_merge
// Gathers the lane results into one frame, zeroes unused lanes and holds it
// in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module lrs_merge (
   input  logic                         clock,
   input  logic                         reset,
   input  lrs_pkg::ctl_type             ctl,
   input  lrs_pkg::sample_type          lane_result [lrs_pkg::LANES],
   input  logic [lrs_pkg::ACH_W-1:0]    active_channels,
   output logic                         advance,
   lrs_rsp_if.source                    rsp
);

   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_last_ff;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_last_ff;
   lrs_pkg::sample_type  out_ff [lrs_pkg::LANES];

   assign advance      = !out_valid_ff || rsp.ready;
   assign s1_valid_in  = advance ? ctl.issue : s1_valid_ff;
   assign out_valid_in = advance ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.issue) begin
         s1_last_ff <= ctl.last;
      end
      if (advance && s1_valid_ff) begin
         out_last_ff <= s1_last_ff;
         for (int i = 0; i < lrs_pkg::LANES; i++) begin
            out_ff[i] <= (lrs_pkg::ACH_W'(i) < active_channels) ? lane_result[i] : '0;
         end
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.out_0       = out_ff[0];
   assign rsp.out_1       = out_ff[1];
   assign rsp.out_2       = out_ff[2];
   assign rsp.out_3       = out_ff[3];
   assign rsp.last_of_run = out_last_ff;

endmodule

>>> rtl/linear_interp_resampler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_interp_resampler_unit
// Four-lane linear interpolation sample rate converter with a Q16 phase.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one input frame (four signed 24-bit samples) per
//   transaction; rsp_ch returns zero to eight interpolated frames for it,
//   the final one flagged by last_of_run. Each result interpolates between
//   the previous frame and this one, so output trails input by one frame.
//   csr_* writes phase_step (index 0) and active_channels (index 1); write
//   them only while the block is idle.
// Timing:
//   A frame is loaded on its transaction; each result is registered in
//   the multiplier stage and then in the output register. The sequencer
//   issues one result per cycle while rsp_ch is not stalled, then updates
//   the phase and the stored frame before it is idle again. One frame is in
//   flight at a time; req_ch.ready is high only while the sequencer is idle.
// Reset:
//   Synchronous; clears the phase and the stored frame to zero, sets
//   phase_step to one and active_channels to two, and empties the outputs.
// Stall:
//   While a result waits and rsp_ch.ready is low, the output register holds
//   it, the multiplier stage holds, no result is issued; nothing is dropped.
// ----------------------------------------------------------------------------
module linear_interp_resampler_unit (
   input  logic                            clock,
   input  logic                            reset,
   lrs_req_if.sink                         req_ch,
   lrs_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  lrs_pkg::csr_index_type          csr_index,
   input  logic [lrs_pkg::PHASE_W-1:0]     csr_wdata
);

   // configuration registers
   logic [lrs_pkg::PHASE_W-1:0]  step_ff;
   logic [lrs_pkg::ACH_W-1:0]    ach_ff;

   lrs_pkg::ctl_type             ctl;
   logic                         advance;
   lrs_pkg::sample_type          frame       [lrs_pkg::LANES];
   lrs_pkg::sample_type          lane_result [lrs_pkg::LANES];

   // drop writes to indexes past the register list
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= lrs_pkg::STEP_RESET;
         ach_ff  <= lrs_pkg::ACH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            lrs_pkg::CSR_PHASE_STEP: step_ff <= csr_wdata;
            lrs_pkg::CSR_ACTIVE_CH:  ach_ff  <= csr_wdata[lrs_pkg::ACH_W-1:0];
            default: ;
         endcase
      end
   end

   // unpack the input frame lane by lane
   assign frame[0] = req_ch.sample_0;
   assign frame[1] = req_ch.sample_1;
   assign frame[2] = req_ch.sample_2;
   assign frame[3] = req_ch.sample_3;

   // sequencer: advance the phase, count results, commit the frame
   lrs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .phase_step (step_ff),
      .advance    (advance),
      .ctl        (ctl)
   );

   // one interpolation core per channel
   for (genvar g = 0; g < lrs_pkg::LANES; g++) begin : g_lane
      lrs_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl),
         .sample (frame[g]),
         .result (lane_result[g])
      );
   end

   // merge lanes into the output register; hold while the receiver stalls
   lrs_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .lane_result     (lane_result),
      .active_channels (ach_ff),
      .advance         (advance),
      .rsp             (rsp_ch)
   );

endmodule

>>> rtl/lrs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_checker
// Port-level checks of the resampler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module lrs_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input lrs_pkg::sample_type  rsp_out_0,
   input logic                 rsp_last
);

   // idle and ready right out of reset
   ready_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> req_ready)
      else $error("input not ready after reset");

   // one frame at a time: busy the cycle after a transaction
   busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input ready right after a transaction");

   // stalled result holds
   hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_out_0) && $stable(rsp_last)))
      else $error("stalled result changed");

   // no result can leave the output register during reset
   quiet_in_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind linear_interp_resampler_unit lrs_checker u_lrs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_out_0 (rsp_ch.out_0),
   .rsp_last  (rsp_ch.last_of_run)
);

>>> dv/linear_interp_resampler_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_interp_resampler_unit_test
// Self-checking bench for the four-lane linear interpolation resampler.
// Frames go in on req_ch and the bench works out, per accepted frame, every
// interpolated frame that rsp_ch must return, from its own copy of the held
// frame, the Q16 phase and both registers. Directed frames hit the sample
// extremes and every register corner; random phases then vary the step and
// lane count, with random idling on both channels, a long result stall and
// a sender pause until the block has drained.
// ----------------------------------------------------------------------------
module linear_interp_resampler_unit_test;

   localparam int  HALF_PERIOD  = 10;
   localparam int  DRAIN_SLACK  = 4;     // lets a frame with no result finish in the sequencer
   localparam int  HOLD_CYCLES  = 80;
   localparam int  PRINT_LIMIT  = 50;
   localparam longint RUN_LIMIT = 5_000_000;

   typedef logic [lrs_pkg::LANES-1:0][lrs_pkg::SAMPLE_W-1:0] lane_vec_type;

   typedef struct packed {
      logic         last;
      lane_vec_type lane;
   } out_frame_type;

   logic clock;
   logic reset;
   logic                          csr_we;
   lrs_pkg::csr_index_type        csr_index;
   logic [lrs_pkg::PHASE_W-1:0]   csr_wdata;

   lrs_req_if req_ch ();
   lrs_rsp_if rsp_ch ();

   linear_interp_resampler_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // interpolator state as the bench sees it
   lane_vec_type                  held_frame;
   logic [lrs_pkg::PHASE_W-1:0]   run_phase;
   logic [lrs_pkg::PHASE_W-1:0]   step_cfg;
   logic [lrs_pkg::ACH_W-1:0]     lanes_cfg;

   out_frame_type expected_frames [$];
   int  mismatch_count;
   bit  quiet;            // no random idling on either side
   bit  offering;         // req_ch.valid as last driven
   bit  hold_request;
   int  hold_left;

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // prev + floor(frac * (cur - prev) / 2^16); the product is exact in 64 bits
   function automatic logic [lrs_pkg::SAMPLE_W-1:0] lerp_lane(
         input logic [lrs_pkg::SAMPLE_W-1:0] a,
         input logic [lrs_pkg::SAMPLE_W-1:0] b,
         input logic [lrs_pkg::FRAC_W-1:0]   frac);
      longint d;
      longint p;
      d = longint'($signed(b)) - longint'($signed(a));
      p = d * longint'(frac);
      return lrs_pkg::SAMPLE_W'(longint'($signed(a)) + (p >>> lrs_pkg::FRAC_W));
   endfunction

   // Queue every interpolated frame this input causes, then advance the phase
   // and keep the input as the new held frame.
   function automatic void interpolate_frame(input lane_vec_type cur);
      logic [lrs_pkg::PHASE_W:0] ph;
      out_frame_type             f;
      int                        lanes;
      int                        n;
      ph    = {1'b0, run_phase};
      lanes = (int'(lanes_cfg) > lrs_pkg::LANES) ? lrs_pkg::LANES : int'(lanes_cfg);
      n     = 0;
      while (ph < lrs_pkg::PHASE_ONE && n < int'(lrs_pkg::MAX_RESULTS)) begin
         for (int i = 0; i < lrs_pkg::LANES; i++) begin
            if (i < lanes) begin
               f.lane[i] = lerp_lane(held_frame[i], cur[i], ph[lrs_pkg::FRAC_W-1:0]);
            end else begin
               f.lane[i] = '0;
            end
         end
         ph = ph + {1'b0, step_cfg};
         n++;
         // last one either because the phase crossed one or the cap was hit
         f.last = (ph >= lrs_pkg::PHASE_ONE) || (n == int'(lrs_pkg::MAX_RESULTS));
         expected_frames.push_back(f);
      end
      if (ph >= lrs_pkg::PHASE_ONE) begin
         ph = ph - lrs_pkg::PHASE_ONE;
      end
      run_phase  = ph[lrs_pkg::PHASE_W-1:0];
      held_frame = cur;
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("%0t ns: mismatch: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   // Compare every result transaction against the oldest expected frame.
   always @(posedge clock) begin : result_check
      out_frame_type want;
      lane_vec_type  got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.out_3, rsp_ch.out_2, rsp_ch.out_1, rsp_ch.out_0};
         if (expected_frames.size() == 0) begin
            report_mismatch("result frame with none expected");
         end else begin
            want = expected_frames.pop_front();
            for (int i = 0; i < lrs_pkg::LANES; i++) begin
               if (got[i] !== want.lane[i]) begin
                  report_mismatch($sformatf("out_%0d got %0d, want %0d", i,
                                            $signed(got[i]), $signed(want.lane[i])));
               end
            end
            if (rsp_ch.last_of_run !== want.last) begin
               report_mismatch($sformatf("last_of_run got %b, want %b",
                                         rsp_ch.last_of_run, want.last));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result side: random idling, plus a long hold-off counted here on request
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (quiet) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= 25);
      end
   end

   // ------------------------------------------------------------------------
   // Frame side
   // ------------------------------------------------------------------------

   // Offer one frame, hold it until the transaction, then predict its results.
   task automatic send_frame(input lane_vec_type s);
      req_ch.valid    <= 1'b1;
      req_ch.sample_0 <= s[0];
      req_ch.sample_1 <= s[1];
      req_ch.sample_2 <= s[2];
      req_ch.sample_3 <= s[3];
      offering = 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      interpolate_frame(s);
      // now and then drop valid for a random pause
      if (!quiet && $urandom_range(0, 99) < 25) begin
         req_ch.valid <= 1'b0;
         offering = 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Stop offering, wait for every expected frame, then let a frame that
   // produces nothing finish in the sequencer.
   task automatic drain_results();
      if (offering) begin
         req_ch.valid <= 1'b0;
         offering = 1'b0;
      end
      while (expected_frames.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // Write both registers back to back; call only with the block drained.
   task automatic set_config(input logic [lrs_pkg::PHASE_W-1:0] step,
                             input logic [lrs_pkg::ACH_W-1:0]   lanes);
      csr_we    <= 1'b1;
      csr_index <= lrs_pkg::CSR_PHASE_STEP;
      csr_wdata <= step;
      @(posedge clock);
      step_cfg = step;
      // random upper bits must be ignored by the lane count register
      csr_index <= lrs_pkg::CSR_ACTIVE_CH;
      csr_wdata <= {(lrs_pkg::PHASE_W-lrs_pkg::ACH_W)'($urandom), lanes};
      @(posedge clock);
      lanes_cfg = lanes;
      csr_we <= 1'b0;
   endtask

   function automatic logic [lrs_pkg::SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return {1'b0, {(lrs_pkg::SAMPLE_W-1){1'b1}}};
         1:       return {1'b1, {(lrs_pkg::SAMPLE_W-1){1'b0}}};
         2:       return '0;
         3:       return lrs_pkg::SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
         default: return lrs_pkg::SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic lane_vec_type pick_frame();
      lane_vec_type s;
      for (int i = 0; i < lrs_pkg::LANES; i++) begin
         s[i] = pick_sample();
      end
      return s;
   endfunction

   function automatic logic [lrs_pkg::PHASE_W-1:0] pick_step();
      case ($urandom_range(0, 9))
         0:       return lrs_pkg::PHASE_W'($urandom_range(0, 8191));
         1:       return lrs_pkg::PHASE_W'($urandom);
         2, 3:    return lrs_pkg::PHASE_W'($urandom_range(8192, 65536));
         default: return lrs_pkg::PHASE_W'($urandom_range(8192, 524288));
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   localparam logic [lrs_pkg::SAMPLE_W-1:0] S_MAX  = {1'b0, {(lrs_pkg::SAMPLE_W-1){1'b1}}};
   localparam logic [lrs_pkg::SAMPLE_W-1:0] S_MIN  = {1'b1, {(lrs_pkg::SAMPLE_W-1){1'b0}}};
   localparam logic [lrs_pkg::SAMPLE_W-1:0] S_NEG1 = '1;
   localparam logic [lrs_pkg::SAMPLE_W-1:0] S_ONE  = lrs_pkg::SAMPLE_W'(1);
   localparam logic [lrs_pkg::SAMPLE_W-1:0] S_ZERO = lrs_pkg::SAMPLE_W'(0);

   // Reset values: unit step, two lanes, zero held frame.
   task automatic test_reset_defaults();
      send_frame({S_NEG1, S_ZERO, S_MIN, S_MAX});
      send_frame({S_NEG1, S_ONE, S_MAX, S_MIN});
      send_frame('0);
      send_frame({lrs_pkg::SAMPLE_W'(24'h5A5A5A), lrs_pkg::SAMPLE_W'(24'hA5A5A5),
                  lrs_pkg::SAMPLE_W'(24'h123456), lrs_pkg::SAMPLE_W'(24'hFEDCBA)});
      drain_results();
   endtask

   // Register corners and sample extremes, with full-scale swings.
   task automatic test_register_corners();
      // half step: midpoint between the extremes, negative rounding
      set_config(lrs_pkg::PHASE_W'(32768), lrs_pkg::ACH_W'(4));
      send_frame({S_MAX, S_MAX, S_MAX, S_MAX});
      send_frame({S_MIN, S_MIN, S_MIN, S_MIN});
      send_frame({S_NEG1, S_ONE, S_NEG1, S_ONE});
      send_frame({S_ONE, S_NEG1, S_MAX, S_MIN});
      drain_results();
      // eighth step: exactly the result cap, then the phase crosses one
      set_config(lrs_pkg::PHASE_W'(8192), lrs_pkg::ACH_W'(3));
      send_frame({S_MIN, S_MAX, S_MIN, S_MAX});
      send_frame({S_MAX, S_MIN, S_MAX, S_MIN});
      drain_results();
      // zero step: capped every frame, phase never advances; no lanes active
      set_config('0, lrs_pkg::ACH_W'(0));
      send_frame({S_MAX, S_MAX, S_MIN, S_MIN});
      send_frame(pick_frame());
      drain_results();
      // step under an eighth: capped, lane count above the lane total
      set_config(lrs_pkg::PHASE_W'(5000), lrs_pkg::ACH_W'(5));
      send_frame({S_MIN, S_MAX, S_ONE, S_NEG1});
      send_frame(pick_frame());
      drain_results();
      // eightfold decimation: mostly frames that return nothing
      set_config(lrs_pkg::PHASE_W'(524288), lrs_pkg::ACH_W'(4));
      send_frame({S_MAX, S_MIN, S_MAX, S_MIN});
      send_frame(pick_frame());
      send_frame(pick_frame());
      drain_results();
      // widest step and the widest lane count
      set_config({lrs_pkg::PHASE_W{1'b1}}, lrs_pkg::ACH_W'(7));
      send_frame({S_MIN, S_MIN, S_MAX, S_MAX});
      send_frame(pick_frame());
      drain_results();
   endtask

   // Random settings, each followed by a burst of random frames.
   task automatic test_random_settings(input int phases, input int frames);
      for (int p = 0; p < phases; p++) begin
         set_config(pick_step(), lrs_pkg::ACH_W'($urandom_range(0, 7)));
         for (int k = 0; k < frames; k++) begin
            send_frame(pick_frame());
         end
         drain_results();
      end
   endtask

   // Hold off the result side long enough that the block stalls its input.
   task automatic test_result_stall();
      set_config(lrs_pkg::PHASE_W'(8192), lrs_pkg::ACH_W'(4));
      hold_request = 1'b1;
      for (int k = 0; k < 20; k++) begin
         send_frame(pick_frame());
      end
      drain_results();
   endtask

   // Pause the frame side until every result has come, mid-sequence.
   task automatic test_sender_pause();
      set_config(lrs_pkg::PHASE_W'(24000), lrs_pkg::ACH_W'(4));
      for (int k = 0; k < 15; k++) begin
         send_frame(pick_frame());
      end
      drain_results();
      for (int k = 0; k < 15; k++) begin
         send_frame(pick_frame());
      end
      drain_results();
   endtask

   // A long stretch with both sides always ready.
   task automatic test_no_idling();
      quiet = 1'b1;
      set_config(lrs_pkg::PHASE_W'($urandom_range(8192, 131072)), lrs_pkg::ACH_W'(4));
      for (int k = 0; k < 60; k++) begin
         send_frame(pick_frame());
      end
      drain_results();
      quiet = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = lrs_pkg::CSR_PHASE_STEP;
      csr_wdata       = '0;
      req_ch.valid    = 1'b0;
      req_ch.sample_0 = '0;
      req_ch.sample_1 = '0;
      req_ch.sample_2 = '0;
      req_ch.sample_3 = '0;
      rsp_ch.ready    = 1'b0;
      quiet           = 1'b0;
      offering        = 1'b0;
      hold_request    = 1'b0;
      hold_left       = 0;
      mismatch_count  = 0;

      held_frame = '0;
      run_phase  = '0;
      step_cfg   = lrs_pkg::STEP_RESET;
      lanes_cfg  = lrs_pkg::ACH_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_register_corners();
      test_random_settings(8, 45);
      test_result_stall();
      test_sender_pause();
      test_no_idling();

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #(RUN_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

endmodule

>>> linear_interp_resampler_unit.f
rtl/lrs_pkg.sv
rtl/lrs_req_if.sv
rtl/lrs_rsp_if.sv
rtl/lrs_ctrl.sv
rtl/lrs_lane.sv
rtl/lrs_merge.sv
rtl/linear_interp_resampler_unit.sv
rtl/lrs_checker.sv
dv/linear_interp_resampler_unit_test.sv
